// ----- sv/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// property checked at every edge
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ----- sv/hbic_pkg.sv -----
// ----------------------------------------------------------------------------
// hbic_pkg
// types, constants and arithmetic shared by the interval classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbic_pkg;

  localparam int unsigned TableBlocksDef = 1048576;
  localparam int unsigned UnitShift      = 16;
  localparam int unsigned UnitW          = 32;
  localparam int unsigned EstW           = 8;
  localparam int unsigned ThrW           = 9;

  localparam logic            OP_USER_WRITE = 1'b0;
  localparam logic            OP_GC         = 1'b1;
  localparam logic [EstW-1:0] EST_MAX       = 8'hFF;

  typedef struct packed {
    logic        opcode;
    logic [31:0] block_addr;
    logic [47:0] segment_age;
  } hbic_in_t;

  typedef struct packed {
    logic [7:0] estimate;
    logic       is_hot;
  } hbic_out_t;

  // saturating add of an 8-bit entry and an age in units
  function automatic logic [EstW-1:0] sat_add(logic [EstW-1:0] base,
                                               logic [UnitW-1:0] units);
    logic [EstW:0] sum;
    sum = {1'b0, base} + {1'b0, units[EstW-1:0]};
    if ((|units[UnitW-1:EstW]) || sum[EstW]) begin
      return EST_MAX;
    end
    return sum[EstW-1:0];
  endfunction

endpackage

// ----- sv/hot_block_interval_classifier_top.sv -----
// ----------------------------------------------------------------------------
// hot_block_interval_classifier_top
// per-block interval estimate table with hot/cold classification
// ----------------------------------------------------------------------------
// Input words (in_valid_i/in_ready_o) carry an opcode, a block address and a
// segment age. A user write returns one result word (out_valid_o/out_ready_i)
// with the saturated estimate and the hot flag, then clears the entry; a
// garbage collection word adds the age in units of 65536 blocks to the entry
// and returns nothing. The threshold is written on the cfg channel, which is
// always ready.
// Each word does one read-modify-write of the table: read in the accept
// cycle, modified and written back when it leaves the modify stage; a result
// goes from the modify-stage registers into the output register. One word per
// cycle is sustained when nothing stalls; a word that hits the entry written
// by the one before it takes the new value through a forwarding register.
// After reset the table is swept to zero, one entry a cycle; in_ready_o
// stays low meanwhile. While the receiver stalls a full output register, a
// user write waiting on it holds the input side; garbage collection words
// keep flowing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hot_block_interval_classifier_top #(
  parameter int unsigned TABLE_BLOCKS = hbic_pkg::TableBlocksDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hbic_pkg::hbic_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hbic_pkg::hbic_out_t       out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [hbic_pkg::ThrW-1:0] cfg_data_i
);
  import hbic_pkg::*;

  localparam int unsigned AddrW    = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
  localparam logic [32:0] TableLim = 33'(TABLE_BLOCKS);

  logic [ThrW-1:0]  thr_q;

  logic             sweep_busy;
  logic [AddrW-1:0] sweep_addr;

  logic             s1_v_q, s1_v_d;
  logic             s1_op_q;
  logic             s1_inr_q;
  logic [AddrW-1:0] s1_idx_q;
  logic [UnitW-1:0] s1_units_q;
  logic             fwd_q;
  logic [EstW-1:0]  fwd_val_q;

  logic             out_v_q, out_v_d;
  hbic_out_t        out_q;

  logic             in_acc;
  logic             in_inr;
  logic [AddrW-1:0] in_idx;
  logic             s1_done;
  logic [EstW-1:0]  rd_data;
  logic [EstW-1:0]  base;
  logic [EstW-1:0]  sum;
  logic [EstW-1:0]  wval;
  logic [EstW-1:0]  est;
  logic             upd_we;
  logic             tbl_we;
  logic [AddrW-1:0] tbl_waddr;
  logic [EstW-1:0]  tbl_wdata;

  hbic_sweep #(
    .Depth (TABLE_BLOCKS),
    .AddrW (AddrW)
  ) u_sweep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (sweep_busy),
    .addr_o (sweep_addr)
  );

  hbic_table #(
    .Depth (TABLE_BLOCKS),
    .AddrW (AddrW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .re_i    (in_acc),
    .raddr_i (in_idx),
    .rdata_o (rd_data)
  );

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  // modify stage
  assign s1_done = s1_v_q && ((s1_op_q == OP_GC) || !out_v_q || out_ready_i);
  assign base    = fwd_q ? fwd_val_q : rd_data;
  assign sum     = sat_add(base, s1_units_q);
  assign wval    = (s1_op_q == OP_GC) ? sum : '0;
  assign est     = s1_inr_q ? sum : EST_MAX;
  assign upd_we  = s1_done && s1_inr_q;

  assign tbl_we    = sweep_busy || upd_we;
  assign tbl_waddr = sweep_busy ? sweep_addr : s1_idx_q;
  assign tbl_wdata = sweep_busy ? '0 : wval;

  // accept
  assign in_ready_o = !sweep_busy && (!s1_v_q || s1_done);
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_inr     = {1'b0, in_data_i.block_addr} < TableLim;
  assign in_idx     = in_data_i.block_addr[AddrW-1:0];

  always_comb begin
    s1_v_d = s1_v_q;
    if (in_acc) begin
      s1_v_d = 1'b1;
    end else if (s1_done) begin
      s1_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q    <= in_data_i.opcode;
      s1_inr_q   <= in_inr;
      s1_idx_q   <= in_idx;
      s1_units_q <= in_data_i.segment_age[UnitShift +: UnitW];
      fwd_q      <= upd_we && (s1_idx_q == in_idx);
      fwd_val_q  <= wval;
    end
  end

  // output register
  always_comb begin
    out_v_d = out_v_q;
    if (s1_done && (s1_op_q == OP_USER_WRITE)) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_done && (s1_op_q == OP_USER_WRITE)) begin
      out_q.estimate <= est;
      out_q.is_hot   <= {1'b0, est} < thr_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/hbic_table.sv -----
// ----------------------------------------------------------------------------
// hbic_table
// interval table: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbic_table #(
  parameter int unsigned Depth = hbic_pkg::TableBlocksDef,
  parameter int unsigned AddrW = 20
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [hbic_pkg::EstW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [hbic_pkg::EstW-1:0] rdata_o
);
  import hbic_pkg::*;

  logic [EstW-1:0] mem_q [Depth];
  logic [EstW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/hbic_sweep.sv -----
// ----------------------------------------------------------------------------
// hbic_sweep
// clearing pass over the table after reset, one entry per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbic_sweep #(
  parameter int unsigned Depth = hbic_pkg::TableBlocksDef,
  parameter int unsigned AddrW = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  output logic             busy_o,
  output logic [AddrW-1:0] addr_o
);
  import hbic_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  logic             busy_q, busy_d;
  logic [AddrW-1:0] cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      if (cnt_q == LastAddr) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = cnt_q;

endmodule

// ----- sv/hbic_checker.sv -----
// ----------------------------------------------------------------------------
// hbic_checker
// port-level checks on the interval classifier, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hbic_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input hbic_pkg::hbic_in_t        in_data_i,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input hbic_pkg::hbic_out_t       out_data_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic [hbic_pkg::ThrW-1:0] cfg_data_i
);
  import hbic_pkg::*;

  logic in_uw;

  // user write word accepted
  assign in_uw = in_valid_i && in_ready_o && (in_data_i.opcode == OP_USER_WRITE);

  `ASSERT_RST(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_RST(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_data_o))
  `ASSERT_RST(a_out_from_word, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_uw, 2))
  `ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_valid_i |-> cfg_ready_o && !$isunknown(cfg_data_i))

endmodule

bind hot_block_interval_classifier_top hbic_checker u_hbic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_data_i  (cfg_data_i)
);
